// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_ALWAYS(label, clk, rstn, !(cond), msg)

`endif

// ===== src/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int S_TDATA_W   = 40;   // func + push_value, byte padded
    localparam int M_TDATA_W   = 40;   // out_value + is_null + overflow, byte padded

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PRINT = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALU_RD2,
        ST_ALU_EXEC,
        ST_RD_OUT,
        ST_FLAG_OUT,
        ST_PR_RD,
        ST_PR_OUT
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_IDX
    } rd_sel_t;

    typedef enum logic {
        WR_PUSH,
        WR_ALU
    } wr_sel_t;

    typedef enum logic [1:0] {
        OUT_RAM,
        OUT_NULL,
        OUT_OVF
    } out_src_t;

    typedef struct packed {
        cnt_op_t  cnt_op;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     alu_sub;
        logic     load_opnd;
        logic     load_idx;
        logic     dec_idx;
        logic     out_load;
        out_src_t out_src;
        logic     out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic cnt_lt2;
        logic idx_zero;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/isc_ram.sv =====
// ----------------------------------------------------------------------------
// isc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/isc_ctrl.sv =====
// ----------------------------------------------------------------------------
// isc_ctrl
// Command sequencer: decodes one command per transfer and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_ctrl
    import isc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire ctrl_stat_t        stat,
    output ctrl_cmd_t              cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [FUNC_W-1:0] func_reg;
    logic              accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_PUSH:  if (stat.cnt_full) state_next = ST_FLAG_OUT;
                        FUNC_POP,
                        FUNC_PEEK:  state_next = stat.cnt_zero ? ST_FLAG_OUT : ST_RD_OUT;
                        FUNC_ADD,
                        FUNC_SUB:   if (!stat.cnt_lt2) state_next = ST_ALU_RD2;
                        FUNC_PRINT: if (!stat.cnt_zero) state_next = ST_PR_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ALU_RD2:  state_next = ST_ALU_EXEC;
            ST_ALU_EXEC: state_next = ST_IDLE;
            ST_RD_OUT,
            ST_FLAG_OUT: if (stat.out_free) state_next = ST_IDLE;
            ST_PR_RD:    state_next = ST_PR_OUT;
            ST_PR_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.idx_zero ? ST_IDLE : ST_PR_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '{cnt_op: CNT_HOLD, rd_en: 1'b0, rd_sel: RD_TOP, wr_en: 1'b0,
                wr_sel: WR_PUSH, alu_sub: 1'b0, load_opnd: 1'b0, load_idx: 1'b0,
                dec_idx: 1'b0, out_load: 1'b0, out_src: OUT_RAM, out_last: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_PUSH: begin
                            if (!stat.cnt_full) begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_PUSH;
                                cmd.cnt_op = CNT_INC;
                            end
                        end
                        FUNC_POP: begin
                            if (!stat.cnt_zero) begin
                                cmd.rd_en  = 1'b1;
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                        FUNC_PEEK: begin
                            cmd.rd_en = !stat.cnt_zero;
                        end
                        FUNC_ADD,
                        FUNC_SUB: begin
                            if (stat.cnt_lt2) begin
                                cmd.cnt_op = CNT_CLR;
                            end else begin
                                cmd.rd_en = 1'b1;
                            end
                        end
                        FUNC_PRINT: begin
                            cmd.load_idx = !stat.cnt_zero;
                        end
                        FUNC_CLEAR: begin
                            cmd.cnt_op = CNT_CLR;
                        end
                        default: begin
                            cmd.cnt_op = CNT_HOLD;
                        end
                    endcase
                end
            end
            ST_ALU_RD2: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_SECOND;
                cmd.load_opnd = 1'b1;
            end
            ST_ALU_EXEC: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_ALU;
                cmd.alu_sub = (func_reg == FUNC_SUB);
                cmd.cnt_op  = CNT_DEC;
            end
            ST_RD_OUT: begin
                cmd.out_load = stat.out_free;
                cmd.out_src  = OUT_RAM;
                cmd.out_last = 1'b1;
            end
            ST_FLAG_OUT: begin
                cmd.out_load = stat.out_free;
                cmd.out_src  = (func_reg == FUNC_PUSH) ? OUT_OVF : OUT_NULL;
                cmd.out_last = 1'b1;
            end
            ST_PR_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
            end
            ST_PR_OUT: begin
                cmd.out_load = stat.out_free;
                cmd.out_src  = OUT_RAM;
                cmd.out_last = stat.idx_zero;
                cmd.dec_idx  = stat.out_free && !stat.idx_zero;
            end
            default: begin
                cmd.cnt_op = CNT_HOLD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/isc_dp.sv =====
// ----------------------------------------------------------------------------
// isc_dp
// Stack datapath: entry counter, stack RAM, adder/subtractor, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module isc_dp
    import isc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [WORD_W-1:0] push_value,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_stat_t             stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    localparam logic [CNT_W-1:0] CntFull = CNT_W'(STACK_DEPTH);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] idx_reg;
    logic [WORD_W-1:0] opnd_reg;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] alu_result;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              m_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic              is_null_reg;
    logic              overflow_reg;
    logic              last_reg;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = cnt_m1;
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_idx) begin
            idx_reg <= cnt_m1[ADDR_W-1:0];
        end else if (cmd.dec_idx) begin
            idx_reg <= idx_reg - ADDR_W'(1);
        end
        if (cmd.load_opnd) begin
            opnd_reg <= rd_data;
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_TOP:    rd_addr = cnt_m1[ADDR_W-1:0];
            RD_SECOND: rd_addr = cnt_m2[ADDR_W-1:0];
            RD_IDX:    rd_addr = idx_reg;
            default:   rd_addr = cnt_m1[ADDR_W-1:0];
        endcase
    end

    // second minus top, or second plus top; wraps mod 2^32
    assign alu_result = cmd.alu_sub ? (rd_data - opnd_reg) : (rd_data + opnd_reg);

    always_comb begin
        case (cmd.wr_sel)
            WR_ALU: begin
                wr_addr = cnt_m2[ADDR_W-1:0];
                wr_data = alu_result;
            end
            default: begin
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = push_value;
            end
        endcase
    end

    isc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= (cmd.out_src == OUT_RAM) ? rd_data : '0;
            is_null_reg   <= (cmd.out_src == OUT_NULL);
            overflow_reg  <= (cmd.out_src == OUT_OVF);
            last_reg      <= cmd.out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - 2){1'b0}}, overflow_reg, is_null_reg,
                       out_value_reg};
    assign m_tlast  = last_reg;

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_full = (count_reg >= CntFull);
    assign stat.cnt_lt2  = (count_reg < CNT_W'(2));
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !m_valid_reg || m_tready;

    `ASSERT_ALWAYS(count_in_range, aclk, aresetn, count_reg <= CntFull, "entry count above depth")
    `ASSERT_NEVER(load_over_pending, aclk, aresetn, cmd.out_load && m_valid_reg && !m_tready, "result overwritten while stalled")
    `ASSERT_NEVER(push_into_full, aclk, aresetn, cmd.wr_en && cmd.wr_sel == WR_PUSH && count_reg == CntFull, "write past top of stack")
    `ASSERT_ALWAYS(pop_needs_entry, aclk, aresetn, cmd.cnt_op == CNT_DEC |-> count_reg != '0, "pop from empty stack")

endmodule

`default_nettype wire

// ===== src/integer_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// integer_stack_calculator
// Bounded stack of signed 32-bit values driven by one command per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries commands: push, pop, add, subtract, peek, print, clear.
//   m_ channel carries results; m_tlast marks the final result of a command.
//   s_tready is high only while the sequencer is idle; a result still held
//   in the output register does not block the next command.
// Steps per command (from accept):
//   push, clear, unused code, add/subtract with fewer than two entries: done at accept.
//   pop, peek: stack RAM registered read, then result load.
//   overflow or null reports: result load after accept.
//   add, subtract: two reads of the single RAM read port, then write.
//   print: index load, then one RAM read and one result load per entry.
// Reset clears the entry count and empties the output register; stack RAM
// contents are left as they are. When the receiver stalls, the result
// holds in the output register and the sequencer waits before loading the
// next one, which lengthens the command by the stall.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_stack_calculator
    import isc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [2:0] func, [34:3] push_value
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // [31:0] out_value, [32] is_null, [33] overflow
    output logic                      m_tlast
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    isc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tdata[FUNC_W-1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    isc_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_value (s_tdata[FUNC_W +: WORD_W]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
